/* rtl/gcg_pkg.sv */
// glyph column generator package: glyph index type, queue slot struct,
// sequencing constants and the 8x8 glyph table
// no dependencies
`timescale 1ns / 1ps

package gcg_pkg;

  localparam int unsigned GlyphSize  = 8;
  localparam int unsigned GlyphCount = 28;
  localparam int unsigned GlyphIdxW  = $clog2(GlyphCount);
  localparam int unsigned RowIdxW    = $clog2(GlyphSize);
  localparam int unsigned StepW      = $clog2(GlyphSize + 1);
  localparam int unsigned GlyphBitsW = GlyphSize * GlyphSize;

  localparam logic [7:0] CodeLowerA  = 8'd97;
  localparam logic [7:0] CodeLowerZ  = 8'd122;
  localparam logic [7:0] CaseOffset  = 8'd32;
  localparam logic [7:0] CodeUpperA  = 8'd65;
  localparam logic [7:0] CodeUpperZ  = 8'd90;
  localparam logic [7:0] CodePeriod  = 8'd46;

  typedef logic [GlyphIdxW-1:0] glyph_idx_t;

  localparam glyph_idx_t GlyphPeriod = glyph_idx_t'(26);
  localparam glyph_idx_t GlyphBlank  = glyph_idx_t'(27);

  typedef enum logic {
    OrientHorizontal = 1'b0,
    OrientVertical   = 1'b1
  } orient_e;

  typedef struct packed {
    logic       valid;
    glyph_idx_t glyph;
  } gcg_slot_t;

  // row r of the glyph sits in bits [8r+7:8r]
  function automatic logic [GlyphBitsW-1:0] glyph_bits(glyph_idx_t idx);
    logic [GlyphBitsW-1:0] bits;
    case (idx)
      5'd0:        bits = 64'hEE44_447C_4444_2810;
      5'd1:        bits = 64'hFC42_4242_7C48_44F8;
      5'd2:        bits = 64'h3A46_8280_8082_463A;
      5'd3:        bits = 64'hF844_4242_4242_44F8;
      5'd4:        bits = 64'hFE42_4040_7840_42FE;
      5'd5:        bits = 64'hE040_4878_4842_42FE;
      5'd6:        bits = 64'h3C42_8292_9E80_423E;
      5'd7:        bits = 64'hEE44_4444_7C44_44EE;
      5'd8:        bits = 64'hFE10_1010_1010_10FE;
      5'd9:        bits = 64'h7088_88C8_0808_083E;
      5'd10:       bits = 64'hEE44_4448_7048_44EE;
      5'd11:       bits = 64'hFE42_4040_4040_40E0;
      5'd12:       bits = 64'hEE44_4444_5454_6CC6;
      5'd13:       bits = 64'hEE44_444C_5454_64CE;
      5'd14:       bits = 64'h3844_8282_8282_4438;
      5'd15:       bits = 64'hE040_4040_7C42_42FC;
      5'd16:       bits = 64'h107C_9282_8282_827C;
      5'd17:       bits = 64'hEE44_4850_7C42_42FC;
      5'd18:       bits = 64'hBCC2_8204_7882_867A;
      5'd19:       bits = 64'h3810_1010_1010_92FE;
      5'd20:       bits = 64'h3844_4444_4444_44EE;
      5'd21:       bits = 64'h1028_4444_4444_44EE;
      5'd22:       bits = 64'h2854_5454_4444_44EE;
      5'd23:       bits = 64'hEE44_2810_1028_44EE;
      5'd24:       bits = 64'h3810_1010_2844_44EE;
      5'd25:       bits = 64'hFE82_4020_1804_82FE;
      GlyphPeriod: bits = 64'hC0C0_0000_0000_0000;
      GlyphBlank:  bits = '0;
      default:     bits = '0;
    endcase
    return bits;
  endfunction

endpackage

/* rtl/gcg_front.sv */
// glyph column generator front: folds and classifies each character code
// and holds the glyph indices in a short queue for the back end
// depends on gcg_pkg
`timescale 1ns / 1ps

module gcg_front
  import gcg_pkg::*;
#(
  parameter int unsigned QueueDepth = 2
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push,
  output logic       full,
  input  logic [7:0] char_code_i,
  output gcg_slot_t  slot_o,
  input  logic       slot_pop_i
);

  localparam int unsigned PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned CntW = $clog2(QueueDepth + 1);

  logic [7:0] folded;
  glyph_idx_t glyph;
  logic       push_ok;
  logic       pop_ok;

  glyph_idx_t mem_q [QueueDepth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;

  // lower-case fold, then letter / period / blank
  always_comb begin
    if (char_code_i >= CodeLowerA && char_code_i <= CodeLowerZ) begin
      folded = char_code_i - CaseOffset;
    end else begin
      folded = char_code_i;
    end
    if (folded >= CodeUpperA && folded <= CodeUpperZ) begin
      glyph = glyph_idx_t'(folded - CodeUpperA);
    end else if (folded == CodePeriod) begin
      glyph = GlyphPeriod;
    end else begin
      glyph = GlyphBlank;
    end
  end

  assign full    = (count_q == CntW'(QueueDepth));
  assign push_ok = push && !full;
  assign pop_ok  = slot_pop_i && (count_q != '0);

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_ok) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_ok) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_ok && !pop_ok) begin
      count_d = count_q + 1'b1;
    end else if (pop_ok && !push_ok) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_ok) begin
      mem_q[wr_ptr_q] <= glyph;
    end
  end

  assign slot_o.valid = (count_q != '0);
  assign slot_o.glyph = mem_q[rd_ptr_q];

endmodule

/* rtl/gcg_back.sv */
// glyph column generator back end: steps through one glyph a byte per
// cycle while its output register is free, rows plus spacer or transposed
// columns, into that output register; depends on gcg_pkg
`timescale 1ns / 1ps

module gcg_back
  import gcg_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  orient_e    orient_i,
  input  gcg_slot_t  slot_i,
  output logic       slot_pop_o,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] cell_byte_o,
  output logic       last_of_char_o
);

  logic                  busy_q, busy_d;
  logic [StepW-1:0]      step_q, step_d;
  glyph_idx_t            glyph_q, glyph_d;
  logic                  out_valid_q, out_valid_d;
  logic [7:0]            byte_q, byte_d;
  logic                  last_q, last_d;

  logic [GlyphBitsW-1:0] bits;
  logic [RowIdxW-1:0]    row_idx;
  logic [RowIdxW-1:0]    col_idx;
  logic [7:0]            col_byte;
  logic [7:0]            cur_byte;
  logic                  at_last;
  logic                  out_free;

  assign bits    = glyph_bits(glyph_q);
  assign row_idx = step_q[RowIdxW-1:0];
  assign col_idx = RowIdxW'(GlyphSize - 1) - row_idx;

  always_comb begin
    for (int r = 0; r < GlyphSize; r++) begin
      col_byte[r] = bits[r*GlyphSize + int'(col_idx)];
    end
  end

  always_comb begin
    if (orient_i == OrientVertical) begin
      at_last  = (step_q == StepW'(GlyphSize));
      cur_byte = at_last ? '0 : bits[int'(row_idx)*GlyphSize +: 8];
    end else begin
      at_last  = (step_q == StepW'(GlyphSize - 1));
      cur_byte = col_byte;
    end
  end

  assign out_free   = !out_valid_q || pop;
  assign slot_pop_o = slot_i.valid && (!busy_q || (out_free && at_last));

  always_comb begin
    busy_d      = busy_q;
    step_d      = step_q;
    glyph_d     = glyph_q;
    out_valid_d = out_valid_q && !pop;
    byte_d      = byte_q;
    last_d      = last_q;
    if (busy_q && out_free) begin
      out_valid_d = 1'b1;
      byte_d      = cur_byte;
      last_d      = at_last;
      if (at_last) begin
        busy_d = 1'b0;
      end else begin
        step_d = step_q + 1'b1;
      end
    end
    if (slot_pop_o) begin
      busy_d  = 1'b1;
      step_d  = '0;
      glyph_d = slot_i.glyph;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      busy_q      <= busy_d;
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    glyph_q <= glyph_d;
    byte_q  <= byte_d;
    last_q  <= last_d;
  end

  assign empty          = !out_valid_q;
  assign cell_byte_o    = byte_q;
  assign last_of_char_o = last_q;

endmodule

/* rtl/glyph_column_generator_unit.sv */
// glyph column generator top level: orientation register, front queue
// and back-end byte sequencer
// depends on gcg_pkg, gcg_front, gcg_back
`timescale 1ns / 1ps

// usage:
//   characters go in through a queue-style port: char_code_i is taken at a
//   clock edge with push high and full low. result bytes come out the same
//   way: cell_byte_o / last_of_char_o are valid while empty is low and are
//   taken at an edge with pop high.
//   orientation (cfg_we_i / cfg_wdata_i) picks vertical rows plus a zero
//   spacer (nine bytes) or horizontal transposed columns 7 down to 0 (eight
//   bytes); change it only while no character is in flight.
//   from an idle block, a character passes through the queue entry, the back
//   end's glyph and step registers and then the output register. the back end
//   emits one byte per cycle while pop keeps the output register free, and
//   that output byte stream sets the sustained rate.
//   the front queue (QueueDepth entries) takes new characters while the back
//   end is still emitting; a stalled receiver holds the output register,
//   then the back end, then the queue, and full rises once it is used up.
//   reset empties the queue and output, and sets horizontal orientation.
module glyph_column_generator_unit
  import gcg_pkg::*;
#(
  parameter int unsigned QueueDepth = 2
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic       cfg_wdata_i,
  input  logic       push,
  output logic       full,
  input  logic [7:0] char_code_i,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] cell_byte_o,
  output logic       last_of_char_o
);

  orient_e   orient_q;
  gcg_slot_t slot;
  logic      slot_pop;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      orient_q <= OrientHorizontal;
    end else if (cfg_we_i) begin
      orient_q <= orient_e'(cfg_wdata_i);
    end
  end

  gcg_front #(
    .QueueDepth(QueueDepth)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push       (push),
    .full       (full),
    .char_code_i(char_code_i),
    .slot_o     (slot),
    .slot_pop_i (slot_pop)
  );

  gcg_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .orient_i      (orient_q),
    .slot_i        (slot),
    .slot_pop_o    (slot_pop),
    .empty         (empty),
    .pop           (pop),
    .cell_byte_o   (cell_byte_o),
    .last_of_char_o(last_of_char_o)
  );

  // spacer closes every vertical run
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && last_of_char_o && orient_q == OrientVertical) |-> (cell_byte_o == 8'd0))
    else $error("vertical run does not end in a zero spacer");

  // no bubble inside a run
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && !empty && !last_of_char_o) |=> !empty)
    else $error("gap in output between bytes of one character");

  // queue never hands a slot to the back end while empty
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    slot_pop |-> slot.valid)
    else $error("back end took from an empty queue");

endmodule

/* dv/tb_glyph_column_generator_unit.sv */
// testbench for glyph_column_generator_unit: drives characters through the
// queue-style ports and checks every emitted row or column byte against a
// built-in glyph predictor; depends on gcg_pkg and the rtl top level
`timescale 1ns / 1ps

module tb_glyph_column_generator_unit;
  import gcg_pkg::*;

  localparam int unsigned WatchdogLimit = 3000;
  localparam int unsigned SettleCycles  = 12;
  localparam int unsigned HoldOffCycles = 300;
  localparam int unsigned PhaseItems    = 60;
  localparam int unsigned RandomPhases  = 7;

  class glyph_scoreboard;
    typedef struct {
      logic [7:0] code;
      logic [7:0] data;
      logic       last;
    } due_t;

    orient_e     orient;
    logic [7:0]  font [GlyphCount][GlyphSize];
    due_t        due_q [$];
    int unsigned errors;

    function new();
      orient = OrientHorizontal;
      errors = 0;
      font = '{
        '{8'h10, 8'h28, 8'h44, 8'h44, 8'h7C, 8'h44, 8'h44, 8'hEE},
        '{8'hF8, 8'h44, 8'h48, 8'h7C, 8'h42, 8'h42, 8'h42, 8'hFC},
        '{8'h3A, 8'h46, 8'h82, 8'h80, 8'h80, 8'h82, 8'h46, 8'h3A},
        '{8'hF8, 8'h44, 8'h42, 8'h42, 8'h42, 8'h42, 8'h44, 8'hF8},
        '{8'hFE, 8'h42, 8'h40, 8'h78, 8'h40, 8'h40, 8'h42, 8'hFE},
        '{8'hFE, 8'h42, 8'h42, 8'h48, 8'h78, 8'h48, 8'h40, 8'hE0},
        '{8'h3E, 8'h42, 8'h80, 8'h9E, 8'h92, 8'h82, 8'h42, 8'h3C},
        '{8'hEE, 8'h44, 8'h44, 8'h7C, 8'h44, 8'h44, 8'h44, 8'hEE},
        '{8'hFE, 8'h10, 8'h10, 8'h10, 8'h10, 8'h10, 8'h10, 8'hFE},
        '{8'h3E, 8'h08, 8'h08, 8'h08, 8'hC8, 8'h88, 8'h88, 8'h70},
        '{8'hEE, 8'h44, 8'h48, 8'h70, 8'h48, 8'h44, 8'h44, 8'hEE},
        '{8'hE0, 8'h40, 8'h40, 8'h40, 8'h40, 8'h40, 8'h42, 8'hFE},
        '{8'hC6, 8'h6C, 8'h54, 8'h54, 8'h44, 8'h44, 8'h44, 8'hEE},
        '{8'hCE, 8'h64, 8'h54, 8'h54, 8'h4C, 8'h44, 8'h44, 8'hEE},
        '{8'h38, 8'h44, 8'h82, 8'h82, 8'h82, 8'h82, 8'h44, 8'h38},
        '{8'hFC, 8'h42, 8'h42, 8'h7C, 8'h40, 8'h40, 8'h40, 8'hE0},
        '{8'h7C, 8'h82, 8'h82, 8'h82, 8'h82, 8'h92, 8'h7C, 8'h10},
        '{8'hFC, 8'h42, 8'h42, 8'h7C, 8'h50, 8'h48, 8'h44, 8'hEE},
        '{8'h7A, 8'h86, 8'h82, 8'h78, 8'h04, 8'h82, 8'hC2, 8'hBC},
        '{8'hFE, 8'h92, 8'h10, 8'h10, 8'h10, 8'h10, 8'h10, 8'h38},
        '{8'hEE, 8'h44, 8'h44, 8'h44, 8'h44, 8'h44, 8'h44, 8'h38},
        '{8'hEE, 8'h44, 8'h44, 8'h44, 8'h44, 8'h44, 8'h28, 8'h10},
        '{8'hEE, 8'h44, 8'h44, 8'h44, 8'h54, 8'h54, 8'h54, 8'h28},
        '{8'hEE, 8'h44, 8'h28, 8'h10, 8'h10, 8'h28, 8'h44, 8'hEE},
        '{8'hEE, 8'h44, 8'h44, 8'h28, 8'h10, 8'h10, 8'h10, 8'h38},
        '{8'hFE, 8'h82, 8'h04, 8'h18, 8'h20, 8'h40, 8'h82, 8'hFE},
        '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'hC0, 8'hC0},
        '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}
      };
    endfunction

    // lower case folds to upper case, anything unknown is blank
    function int unsigned glyph_of(logic [7:0] code);
      logic [7:0] up;
      up = code;
      if (code >= CodeLowerA && code <= CodeLowerZ) up = code - CaseOffset;
      if (up >= CodeUpperA && up <= CodeUpperZ) return int'(up - CodeUpperA);
      if (up == CodePeriod) return int'(GlyphPeriod);
      return int'(GlyphBlank);
    endfunction

    function void note_char(logic [7:0] code);
      int unsigned g;
      due_t        e;
      logic [7:0]  col;
      g = glyph_of(code);
      e.code = code;
      if (orient == OrientVertical) begin
        for (int r = 0; r < GlyphSize; r++) begin
          e.data = font[g][r];
          e.last = 1'b0;
          due_q.push_back(e);
        end
        e.data = 8'h00;
        e.last = 1'b1;
        due_q.push_back(e);
      end else begin
        for (int c = GlyphSize - 1; c >= 0; c--) begin
          for (int r = 0; r < GlyphSize; r++) col[r] = font[g][r][c];
          e.data = col;
          e.last = (c == 0);
          due_q.push_back(e);
        end
      end
    endfunction

    function int unsigned pending();
      return due_q.size();
    endfunction

    task report(string what, int got, int want, logic [7:0] code);
      if (errors < 40) begin
        $display("[%0t] mismatch %s: got %0h want %0h (char %0h, %s)",
                 $realtime, what, got, want, code, orient.name());
      end
      errors++;
    endtask

    task check_byte(logic [7:0] data, logic last);
      due_t e;
      if (due_q.size() == 0) begin
        report("unexpected transfer", data, 0, 8'h00);
        return;
      end
      e = due_q.pop_front();
      if (data !== e.data) report("cell_byte", data, e.data, e.code);
      if (last !== e.last) report("last_of_char", last, e.last, e.code);
    endtask
  endclass

  localparam logic [7:0] CornerCodes [12] = '{
    CodeUpperA, CodeUpperZ, CodeLowerA, CodeLowerZ, CodePeriod, 8'h00, 8'hFF,
    CodeUpperA - 8'd1, CodeUpperZ + 8'd1, CodeLowerA - 8'd1, CodeLowerZ + 8'd1, 8'h80
  };

  logic       clk_i;
  logic       rst_ni;
  logic       cfg_we_i;
  logic       cfg_wdata_i;
  logic       push;
  logic       full;
  logic [7:0] char_code_i;
  logic       empty;
  logic       pop;
  logic [7:0] cell_byte_o;
  logic       last_of_char_o;

  glyph_scoreboard board;
  bit              tx_calm;
  bit              rx_calm;
  int unsigned     rx_hold_cycles;
  int unsigned     quiet_cycles;

  glyph_column_generator_unit dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .push           (push),
    .full           (full),
    .char_code_i    (char_code_i),
    .empty          (empty),
    .pop            (pop),
    .cell_byte_o    (cell_byte_o),
    .last_of_char_o (last_of_char_o)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (!rst_ni || (push && !full) || (pop && !empty)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WatchdogLimit) begin
      $display("status: fail");
      $finish;
    end
  end

  function automatic int unsigned pick_gap(input bit calm);
    int unsigned k;
    if (calm) return 0;
    k = $urandom_range(0, 99);
    if (k < 55) return 0;
    if (k < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [7:0] rand_char();
    int unsigned k;
    k = $urandom_range(0, 9);
    if (k < 3) return 8'($urandom_range(CodeUpperA, CodeUpperZ));
    if (k < 6) return 8'($urandom_range(CodeLowerA, CodeLowerZ));
    if (k == 6) return CodePeriod;
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic send_char(input logic [7:0] code);
    int unsigned g;
    g = pick_gap(tx_calm);
    if (g > 0) begin
      push <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
    push <= 1'b1;
    char_code_i <= code;
    do @(posedge clk_i); while (full);
    board.note_char(code);
  endtask

  task automatic drain_results();
    int unsigned g;
    forever begin
      g = pick_gap(rx_calm) + rx_hold_cycles;
      rx_hold_cycles = 0;
      if (g > 0) begin
        pop <= 1'b0;
        repeat (g) @(posedge clk_i);
      end
      pop <= 1'b1;
      do @(posedge clk_i); while (empty);
      board.check_byte(cell_byte_o, last_of_char_o);
    end
  endtask

  task automatic wait_idle();
    while (board.pending() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic set_orientation(input orient_e mode);
    wait_idle();
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= mode;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    board.orient = mode;
  endtask

  initial begin
    clk_i = 1'b0;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_wdata_i = 1'b0;
    push = 1'b0;
    pop = 1'b0;
    char_code_i = 8'h00;
    tx_calm = 1'b0;
    rx_calm = 1'b0;
    rx_hold_cycles = 0;
    board = new();
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    fork
      drain_results();
    join_none

    // reset orientation first, then vertical
    foreach (CornerCodes[i]) send_char(CornerCodes[i]);
    push <= 1'b0;
    set_orientation(OrientVertical);
    foreach (CornerCodes[i]) send_char(CornerCodes[i]);
    push <= 1'b0;

    for (int p = 0; p < RandomPhases; p++) begin
      if (p == 0) set_orientation(OrientHorizontal);
      else if (p == 1) set_orientation(OrientVertical);
      else set_orientation(orient_e'($urandom_range(0, 1)));
      tx_calm = (p % 3 == 2);
      rx_calm = (p % 4 == 3);
      // receiver backs off so the input queue fills and full rises
      if (p == 1) rx_hold_cycles = HoldOffCycles;
      for (int n = 0; n < PhaseItems; n++) send_char(rand_char());
      push <= 1'b0;
    end

    wait_idle();
    repeat (SettleCycles) @(posedge clk_i);
    if (board.errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/gcg_pkg.sv
rtl/gcg_front.sv
rtl/gcg_back.sv
rtl/glyph_column_generator_unit.sv
dv/tb_glyph_column_generator_unit.sv
